// ===== rtl/rsfa_pkg.sv =====
package rsfa_pkg;

    // Opcodes of an input word
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    // Result status codes
    typedef enum logic [2:0] {
        ST_APPENDED   = 3'd0,
        ST_DROPPED    = 3'd1,
        ST_READ_OK    = 3'd2,
        ST_NOT_READY  = 3'd3,
        ST_BAD_OFFSET = 3'd4,
        ST_CLEARED    = 3'd5
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_EXPECTED_LENGTH     = 2'd0,
        CFG_MAX_ROUNDS          = 2'd1,
        CFG_ROUNDS_NEEDED       = 2'd2,
        CFG_BYTES_BEFORE_MARKER = 2'd3
    } t_cfg_idx;

    localparam int LEN_W    = 13;
    localparam int ROUND_W  = 4;
    localparam int BBM_W    = 12;
    localparam int OFFSET_W = 12;
    localparam int CFG_W    = 13;
    localparam int PROD_W   = LEN_W + ROUND_W;
    localparam int GPS_N    = 5;

    localparam logic [LEN_W-1:0]   RST_EXPECTED_LENGTH = 13'd64;
    localparam logic [ROUND_W-1:0] RST_MAX_ROUNDS      = 4'd3;
    localparam logic [ROUND_W-1:0] RST_ROUNDS_NEEDED   = 4'd2;

    localparam logic [7:0] MARK_TYPE  = 8'h35; // '5'
    localparam logic [7:0] MARK_VALUE = 8'h23; // '#'

    localparam logic [3:0] MARKER_SAT  = 4'd15;
    localparam logic [3:0] MIN_MARKERS = 4'd3;

    // GPS type characters in latch order: G, Y, N, D, H
    localparam logic [7:0] GPS_TYPES [GPS_N] = '{8'h47, 8'h59, 8'h4E, 8'h44, 8'h48};

    typedef struct packed {
        t_status            status;
        logic [7:0]         data_byte;
        logic [GPS_N-1:0][7:0] gps;
        logic [GPS_N-1:0]   gps_mask;
    } t_result;

endpackage

// ===== rtl/rsfa_in_if.sv =====
interface rsfa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  data_type;
    logic [7:0]  data_value;
    logic [11:0] read_offset;

    modport source (output valid, opcode, data_type, data_value, read_offset, input ready);
    modport sink   (input valid, opcode, data_type, data_value, read_offset, output ready);
endinterface

// ===== rtl/rsfa_out_if.sv =====
interface rsfa_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] data_byte;
    logic [7:0] gps_signal_status;
    logic [7:0] gps_year;
    logic [7:0] gps_month;
    logic [7:0] gps_day;
    logic [7:0] gps_hour;
    logic [4:0] gps_set_mask;

    modport source (output valid, status, data_byte, gps_signal_status, gps_year,
                    gps_month, gps_day, gps_hour, gps_set_mask, input ready);
    modport sink   (input valid, status, data_byte, gps_signal_status, gps_year,
                    gps_month, gps_day, gps_hour, gps_set_mask, output ready);
endinterface

// ===== rtl/rsfa_ram.sv =====
module rsfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rsfa_track.sv =====
module rsfa_track
    import rsfa_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16384
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [CFG_W-1:0]                i_cfg_wdata,
    input  logic                            i_acc,
    input  logic [1:0]                      i_opcode,
    input  logic [7:0]                      i_data_type,
    input  logic [7:0]                      i_data_value,
    input  logic [OFFSET_W-1:0]             i_read_offset,
    output logic                            o_ram_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_ram_waddr,
    output logic [7:0]                      o_ram_wdata,
    output logic                            o_ram_re,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_ram_raddr,
    output t_result                         o_res,
    output logic                            o_rd_ok
);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = (CW > PROD_W) ? CW : PROD_W;
    localparam int IW = ((AW > BBM_W) ? AW : BBM_W) + 1;

    // Configuration registers
    logic [LEN_W-1:0]   r_exp_len;
    logic [ROUND_W-1:0] r_max_rounds;
    logic [ROUND_W-1:0] r_rounds_needed;
    logic [BBM_W-1:0]   r_bbm;

    // Buffer bookkeeping
    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [3:0]    r_marker_count, n_marker_count;
    logic [AW-1:0] r_last_pos, n_last_pos;
    logic          r_aligned, n_aligned;
    logic [AW-1:0] r_aligned_start, n_aligned_start;
    logic [7:0]    r_gps [GPS_N];
    logic [7:0]    n_gps [GPS_N];
    logic [GPS_N-1:0] r_gps_mask, n_gps_mask;

    logic [PW-1:0] keep_limit;
    logic [PW-1:0] ready_limit;
    logic [PW-1:0] count_ext;
    logic [PW-1:0] gap;
    logic [IW-1:0] rd_idx;
    logic          drop;
    logic          is_marker;
    t_status       status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len       <= RST_EXPECTED_LENGTH;
            r_max_rounds    <= RST_MAX_ROUNDS;
            r_rounds_needed <= RST_ROUNDS_NEEDED;
            r_bbm           <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_EXPECTED_LENGTH:     r_exp_len       <= i_cfg_wdata;
                CFG_MAX_ROUNDS:          r_max_rounds    <= i_cfg_wdata[ROUND_W-1:0];
                CFG_ROUNDS_NEEDED:       r_rounds_needed <= i_cfg_wdata[ROUND_W-1:0];
                CFG_BYTES_BEFORE_MARKER: r_bbm           <= i_cfg_wdata[BBM_W-1:0];
                default: ;
            endcase
        end
    end

    // Limits from the current configuration
    assign keep_limit  = PW'(PROD_W'(r_exp_len) * PROD_W'(r_max_rounds));
    assign ready_limit = PW'(PROD_W'(r_exp_len) * PROD_W'(r_rounds_needed));
    assign count_ext   = PW'(r_byte_count);
    assign gap         = PW'(r_byte_count - CW'(r_last_pos));
    assign rd_idx      = IW'(r_aligned_start) + IW'(i_read_offset);
    assign drop        = (count_ext > keep_limit) || (r_byte_count == CW'(BUFFER_DEPTH));
    assign is_marker   = (i_data_type == MARK_TYPE) && (i_data_value == MARK_VALUE);

    // Decode the word and work out the next bookkeeping state
    always_comb begin
        n_byte_count    = r_byte_count;
        n_marker_count  = r_marker_count;
        n_last_pos      = r_last_pos;
        n_aligned       = r_aligned;
        n_aligned_start = r_aligned_start;
        n_gps           = r_gps;
        n_gps_mask      = r_gps_mask;
        o_ram_we        = 1'b0;
        o_ram_re        = 1'b0;
        o_rd_ok         = 1'b0;
        status          = ST_DROPPED;

        case (t_opcode'(i_opcode))
            OP_APPEND: begin
                if (!drop) begin
                    status   = ST_APPENDED;
                    o_ram_we = i_acc;
                    if (is_marker) begin
                        if ((r_marker_count != 4'd0) && !r_aligned
                            && (IW'(r_last_pos) >= IW'(r_bbm))
                            && (gap == PW'(r_exp_len))) begin
                            n_aligned       = 1'b1;
                            n_aligned_start = r_last_pos;
                        end
                        n_last_pos = r_byte_count[AW-1:0];
                        if (r_marker_count != MARKER_SAT) begin
                            n_marker_count = r_marker_count + 4'd1;
                        end
                    end
                    n_byte_count = r_byte_count + CW'(1);
                    for (int k = 0; k < GPS_N; k++) begin
                        if ((i_data_type == GPS_TYPES[k]) && !r_gps_mask[k]) begin
                            n_gps[k]      = i_data_value;
                            n_gps_mask[k] = 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                if (!(count_ext > ready_limit) || (r_marker_count < r_rounds_needed)
                    || (r_marker_count < MIN_MARKERS) || !r_aligned) begin
                    status = ST_NOT_READY;
                end else if ((LEN_W'(i_read_offset) >= r_exp_len)
                             || (rd_idx >= IW'(r_byte_count))) begin
                    status = ST_BAD_OFFSET;
                end else begin
                    status   = ST_READ_OK;
                    o_rd_ok  = 1'b1;
                    o_ram_re = i_acc;
                end
            end
            OP_CLEAR: begin
                status          = ST_CLEARED;
                n_byte_count    = '0;
                n_marker_count  = '0;
                n_last_pos      = '0;
                n_aligned       = 1'b0;
                n_aligned_start = '0;
            end
            default: status = ST_DROPPED;
        endcase
    end

    // Commit on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_marker_count  <= '0;
            r_last_pos      <= '0;
            r_aligned       <= 1'b0;
            r_aligned_start <= '0;
            r_gps           <= '{default: '0};
            r_gps_mask      <= '0;
        end else if (i_acc) begin
            r_byte_count    <= n_byte_count;
            r_marker_count  <= n_marker_count;
            r_last_pos      <= n_last_pos;
            r_aligned       <= n_aligned;
            r_aligned_start <= n_aligned_start;
            r_gps           <= n_gps;
            r_gps_mask      <= n_gps_mask;
        end
    end

    assign o_ram_waddr = r_byte_count[AW-1:0];
    assign o_ram_wdata = i_data_value;
    assign o_ram_raddr = rd_idx[AW-1:0];

    // Result fields, GPS values as they stand after this word
    always_comb begin
        o_res.status    = status;
        o_res.data_byte = '0;
        for (int k = 0; k < GPS_N; k++) begin
            o_res.gps[k] = n_gps[k];
        end
        o_res.gps_mask = n_gps_mask;
    end
endmodule

// ===== rtl/rsfa_out.sv =====
module rsfa_out
    import rsfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  t_result    i_res,
    input  logic       i_rd_ok,
    input  logic [7:0] i_rdata,
    input  logic       i_take,
    output logic       o_in_ready,
    output logic       o_valid,
    output t_result    o_res
);
    logic    r_s1_valid;
    logic    r_s1_rd;
    t_result r_s1_res;
    t_result s1_out;
    logic    r_o_valid;
    t_result r_o_res;
    logic    s1_adv;

    // Stage 1 moves on when the output register is free or being emptied
    assign s1_adv     = r_s1_valid && (!r_o_valid || i_take);
    assign o_in_ready = !r_s1_valid || s1_adv;

    // Stage 1 waits for the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_res <= i_res;
            r_s1_rd  <= i_rd_ok;
        end
    end

    // Merge the store byte into the stage 1 word
    always_comb begin
        s1_out           = r_s1_res;
        s1_out.data_byte = r_s1_rd ? i_rdata : 8'd0;
    end

    // Output register, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_res <= s1_out;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_o_res;
endmodule

// ===== rtl/rolling_status_frame_aligner.sv =====
// Rolling status frame aligner.
// Input channel i_item carries one word per command: append a type/value pair,
// read one byte of the aligned frame, or clear the buffer. Every accepted word
// gives exactly one result word on o_result: a status, the read byte (zero
// unless the read succeeded) and the first latched GPS status values.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while
// the block is idle; register i of the list has index i.
// Throughput: one word per cycle while o_result.ready is high. The value
// store is a single-port-write, registered-read memory; all buffer
// bookkeeping is updated in the accept cycle, and the store read data is
// registered as the word enters stage 1. The result word then moves from
// stage 1 to the output register, where o_result.valid rises for it.
// Stalls: the output register holds its word while o_result.ready is low;
// stage 1 fills behind it, and i_item.ready drops only when both are full.
// Reset: counts, markers, alignment and GPS latches clear at once and the
// configuration returns to its defaults; the store needs no clearing pass,
// since a read never reaches a position that was not appended since clear.
module rolling_status_frame_aligner
    import rsfa_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    rsfa_in_if.sink          i_item,
    rsfa_out_if.source       o_result
);
    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          acc;
    logic          in_ready;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic          rd_ok;
    t_result       issue_res;
    t_result       out_res;

    assign acc          = i_item.valid && in_ready;
    assign i_item.ready = in_ready;

    rsfa_track #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_acc        (acc),
        .i_opcode     (i_item.opcode),
        .i_data_type  (i_item.data_type),
        .i_data_value (i_item.data_value),
        .i_read_offset(i_item.read_offset),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .o_res        (issue_res),
        .o_rd_ok      (rd_ok)
    );

    rsfa_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    rsfa_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_res     (issue_res),
        .i_rd_ok   (rd_ok),
        .i_rdata   (ram_rdata),
        .i_take    (o_result.ready),
        .o_in_ready(in_ready),
        .o_valid   (o_result.valid),
        .o_res     (out_res)
    );

    // Drive the result word
    assign o_result.status            = out_res.status;
    assign o_result.data_byte         = out_res.data_byte;
    assign o_result.gps_signal_status = out_res.gps[0];
    assign o_result.gps_year          = out_res.gps[1];
    assign o_result.gps_month         = out_res.gps[2];
    assign o_result.gps_day           = out_res.gps[3];
    assign o_result.gps_hour          = out_res.gps[4];
    assign o_result.gps_set_mask      = out_res.gps_mask;
endmodule
